>>> design/serial_frame_parser_defines.svh
// ---------------------------------------------------------------------------
// serial_frame_parser_defines
// Assertion macros shared by the frame parser modules.
// ---------------------------------------------------------------------------
`ifndef SERIAL_FRAME_PARSER_DEFINES_SVH
`define SERIAL_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent holds, consequent holds in the same cycle
`define SFP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("serial_frame_parser: assertion failed");

// antecedent holds, consequent holds in the next cycle
`define SFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("serial_frame_parser: assertion failed");

`else

`define SFP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define SFP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> design/sfp_pkg.sv
// ---------------------------------------------------------------------------
// sfp_pkg
// Types and constants shared by the serial frame parser modules.
// ---------------------------------------------------------------------------
package sfp_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int HEAD_BYTES          = 6;

  localparam logic [7:0] START_ONE    = 8'h5A;
  localparam logic [7:0] START_TWO    = 8'hA5;
  localparam logic [7:0] KIND_CONTROL = 8'h55;
  localparam logic [7:0] KIND_STATUS  = 8'hAA;
  localparam logic [7:0] LEN_MIN      = 8'd5;
  localparam logic [7:0] LEN_OVERHEAD = 8'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_XOR_MODE = 3'd0,
    CFG_IDS_0    = 3'd1,
    CFG_IDS_1    = 3'd2,
    CFG_IDS_2    = 3'd3,
    CFG_IDS_3    = 3'd4
  } sfp_cfg_index_t;

  typedef struct packed {
    logic                   en;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
  } sfp_cfg_wr_t;

  // one classified byte on its way from front to back
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_one;
    logic       start_two;
    logic       len_ok;
    logic       kind_control;
    logic       kind_status;
    logic       id_ok;
  } sfp_item_t;

  typedef struct packed {
    logic        is_status_frame;
    logic [7:0]  frame_ident;
    logic [7:0]  sequence_count;
    logic [7:0]  received_sum;
    logic        sum_ok;
    logic [4:0]  payload_length;
    logic [47:0] payload_head;
    logic [31:0] good_frames_total;
    logic [31:0] bad_frames_total;
  } sfp_result_t;

endpackage

>>> design/sfp_front.sv
// ---------------------------------------------------------------------------
// sfp_front
// Byte intake: classifies each received byte and holds the ID accept mask.
// ---------------------------------------------------------------------------
module sfp_front #(
  parameter int MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  sfp_pkg::sfp_cfg_wr_t cfg,
  input  logic                rx_valid,
  output logic                rx_ready,
  input  logic [7:0]          rx_byte,
  output logic                q_valid,
  input  logic                q_ready,
  output sfp_pkg::sfp_item_t  q_item
);
  import sfp_pkg::*;

  localparam logic [8:0] LEN_MAX = 9'(4 + MAX_PAYLOAD);

  logic [63:0] accept_ids [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        accept_ids[i] <= '1;
      end
    end else if (cfg.en) begin
      case (cfg.index)
        CFG_IDS_0: accept_ids[0] <= cfg.data;
        CFG_IDS_1: accept_ids[1] <= cfg.data;
        CFG_IDS_2: accept_ids[2] <= cfg.data;
        CFG_IDS_3: accept_ids[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    q_item.rx_byte      = rx_byte;
    q_item.start_one    = (rx_byte == START_ONE);
    q_item.start_two    = (rx_byte == START_TWO);
    q_item.len_ok       = (rx_byte >= LEN_MIN) && ({1'b0, rx_byte} <= LEN_MAX);
    q_item.kind_control = (rx_byte == KIND_CONTROL);
    q_item.kind_status  = (rx_byte == KIND_STATUS);
    q_item.id_ok        = accept_ids[rx_byte[7:6]][rx_byte[5:0]];
  end

  assign q_valid  = rx_valid;
  assign rx_ready = q_ready;

endmodule

>>> design/sfp_fifo.sv
// ---------------------------------------------------------------------------
// sfp_fifo
// Short queue of classified bytes between the front and the back.
// ---------------------------------------------------------------------------
`include "serial_frame_parser_defines.svh"

module sfp_fifo #(
  parameter int DEPTH = sfp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  sfp_pkg::sfp_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output sfp_pkg::sfp_item_t pop_item
);
  import sfp_pkg::*;

  // user keeps depth a power of two so pointers wrap on their own; unenforced
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfp_item_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `SFP_ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH))
  `SFP_ASSERT_IMPLIES(a_ptr_gap, clk, rst, DEPTH > 1, (wr_ptr - rd_ptr) == PTR_W'(count))
  `SFP_ASSERT_NEXT(a_push_only, clk, rst, push && !pop, count == CNT_W'($past(count) + 1'b1))

endmodule

>>> design/sfp_back.sv
// ---------------------------------------------------------------------------
// sfp_back
// Frame state machine: running checksum, payload capture, frame counters
// and the result register.
// ---------------------------------------------------------------------------
`include "serial_frame_parser_defines.svh"

module sfp_back #(
  parameter int MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sfp_pkg::sfp_cfg_wr_t cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sfp_pkg::sfp_item_t   q_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output sfp_pkg::sfp_result_t res
);
  import sfp_pkg::*;

  localparam int IDX_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [7:0] {
    S_START_ONE = 8'b0000_0001,
    S_START_TWO = 8'b0000_0010,
    S_LENGTH    = 8'b0000_0100,
    S_TYPE      = 8'b0000_1000,
    S_IDENT     = 8'b0001_0000,
    S_PAYLOAD   = 8'b0010_0000,
    S_COUNT     = 8'b0100_0000,
    S_SUM       = 8'b1000_0000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic             xor_mode;
  logic [7:0]       length_byte;
  logic             type_is_status;
  logic [7:0]       ident_byte;
  logic [7:0]       count_byte;
  logic [7:0]       running_sum;
  logic [IDX_W-1:0] payload_index;
  logic [IDX_W-1:0] index_inc;
  logic [7:0]       payload_store [HEAD_BYTES];
  logic [31:0]      good_total;
  logic [31:0]      bad_total;
  logic             fire;
  logic [7:0]       b;
  logic [7:0]       folded;
  logic [7:0]       folded_first;
  logic             payload_done;
  logic             sum_match;

  // only the checksum byte has to wait for a free result register
  assign q_ready      = !res_valid || res_ready || (state != S_SUM);
  assign fire         = q_valid && q_ready;
  assign b            = q_item.rx_byte;
  assign folded       = xor_mode ? (running_sum ^ b) : (running_sum + b);
  assign folded_first = b;
  assign index_inc    = payload_index + 1'b1;
  assign payload_done = 8'(index_inc) >= (length_byte - LEN_OVERHEAD);
  assign sum_match    = (running_sum == b);

  always_ff @(posedge clk) begin
    if (rst) begin
      xor_mode <= 1'b0;
    end else if (cfg.en && cfg.index == CFG_XOR_MODE) begin
      xor_mode <= cfg.data[0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_START_ONE: if (q_item.start_one) state_next = S_START_TWO;
      S_START_TWO: state_next = q_item.start_two ? S_LENGTH : S_START_ONE;
      S_LENGTH:    state_next = q_item.len_ok ? S_TYPE : S_START_ONE;
      S_TYPE: begin
        state_next = (q_item.kind_control || q_item.kind_status) ? S_IDENT : S_START_ONE;
      end
      S_IDENT:     state_next = q_item.id_ok ? S_PAYLOAD : S_START_ONE;
      S_PAYLOAD:   if (payload_done) state_next = S_COUNT;
      S_COUNT:     state_next = S_SUM;
      S_SUM:       state_next = S_START_ONE;
      default:     state_next = S_START_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_START_ONE;
      good_total <= '0;
      bad_total  <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (fire && state == S_SUM) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (fire) begin
        state <= state_next;
        if (state == S_SUM) begin
          if (sum_match) begin
            good_total <= good_total + 1'b1;
          end else begin
            bad_total <= bad_total + 1'b1;
          end
        end
      end
    end
  end

  // frame fields, written before they are read in every frame
  always_ff @(posedge clk) begin
    if (fire) begin
      case (state)
        S_START_ONE: begin
          if (q_item.start_one) begin
            length_byte    <= '0;
            type_is_status <= 1'b0;
            ident_byte     <= '0;
            count_byte     <= '0;
            payload_index  <= '0;
            running_sum    <= folded_first;
            for (int i = 0; i < HEAD_BYTES; i++) begin
              payload_store[i] <= '0;
            end
          end
        end
        S_START_TWO: begin
          if (q_item.start_two) running_sum <= folded;
        end
        S_LENGTH: begin
          if (q_item.len_ok) begin
            length_byte <= b;
            running_sum <= folded;
          end
        end
        S_TYPE: begin
          if (q_item.kind_control || q_item.kind_status) begin
            type_is_status <= q_item.kind_status;
            running_sum    <= folded;
          end
        end
        S_IDENT: begin
          if (q_item.id_ok) begin
            ident_byte  <= b;
            running_sum <= folded;
          end
        end
        S_PAYLOAD: begin
          // bytes past the head are summed but not kept
          if (payload_index < IDX_W'(HEAD_BYTES)) begin
            payload_store[payload_index[2:0]] <= b;
          end
          payload_index <= index_inc;
          running_sum   <= folded;
        end
        S_COUNT: begin
          count_byte  <= b;
          running_sum <= folded;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire && state == S_SUM) begin
      res.is_status_frame   <= type_is_status;
      res.frame_ident       <= ident_byte;
      res.sequence_count    <= count_byte;
      res.received_sum      <= b;
      res.sum_ok            <= sum_match;
      res.payload_length    <= 5'(length_byte - LEN_OVERHEAD);
      res.payload_head      <= {payload_store[5], payload_store[4], payload_store[3],
                                payload_store[2], payload_store[1], payload_store[0]};
      res.good_frames_total <= sum_match ? (good_total + 1'b1) : good_total;
      res.bad_frames_total  <= sum_match ? bad_total : (bad_total + 1'b1);
    end
  end

  `SFP_ASSERT_NEXT(a_sum_emits, clk, rst, fire && state == S_SUM, res_valid)
  `SFP_ASSERT_IMPLIES(a_index_in_frame, clk, rst, state == S_PAYLOAD,
                      8'(payload_index) < (length_byte - LEN_OVERHEAD))
  `SFP_ASSERT_IMPLIES(a_totals_match, clk, rst, res_valid,
                      res.good_frames_total == good_total && res.bad_frames_total == bad_total)

endmodule

>>> design/serial_frame_parser.sv
// ---------------------------------------------------------------------------
// serial_frame_parser
// Hunts serial byte streams for framed messages and reports each frame.
// ---------------------------------------------------------------------------
// Bytes enter on rx_byte with rx_valid/rx_ready; each completed frame leaves
// as one result on out_valid/out_ready, on the transfer of its checksum byte.
// Framing: 0x5A 0xA5, length, type (0x55/0xAA), ID, length-4 payload bytes,
// count byte, checksum byte. Bad length, type or masked ID drops the frame
// silently. cfg_write_en/cfg_index/cfg_data set the checksum mode (index 0)
// and the four 64-bit ID accept masks (indexes 1..4); write only when idle.
// Throughput is one byte per cycle while the back is not stalled at a
// checksum byte: the front classifies a byte in the transfer cycle, a
// QUEUE_DEPTH entry queue holds it, and the back state machine folds it
// into the running sum. With no stall, the checksum byte is first written
// into the queue; its pop by the back loads the result and sets out_valid.
// Reset clears the hunt, the counters, the mode (additive) and sets all masks
// to accept every ID. When out_ready is low the result register holds; the
// back keeps folding bytes up to the next checksum byte and stalls there,
// then the queue fills and rx_ready drops.
// ---------------------------------------------------------------------------
module serial_frame_parser #(
  parameter int MAX_PAYLOAD = sfp_pkg::MAX_PAYLOAD_DEFAULT,
  parameter int QUEUE_DEPTH = sfp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [sfp_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sfp_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             rx_valid,
  output logic                             rx_ready,
  input  logic [7:0]                       rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             is_status_frame,
  output logic [7:0]                       frame_ident,
  output logic [7:0]                       sequence_count,
  output logic [7:0]                       received_sum,
  output logic                             sum_ok,
  output logic [4:0]                       payload_length,
  output logic [47:0]                      payload_head,
  output logic [31:0]                      good_frames_total,
  output logic [31:0]                      bad_frames_total
);
  import sfp_pkg::*;

  sfp_cfg_wr_t cfg;
  sfp_item_t   front_item;
  sfp_item_t   back_item;
  sfp_result_t res;
  logic        front_valid;
  logic        front_ready;
  logic        back_valid;
  logic        back_ready;

  assign cfg.en    = cfg_write_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  sfp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_byte  (rx_byte),
    .q_valid  (front_valid),
    .q_ready  (front_ready),
    .q_item   (front_item)
  );

  sfp_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  sfp_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (back_valid),
    .q_ready   (back_ready),
    .q_item    (back_item),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign is_status_frame   = res.is_status_frame;
  assign frame_ident       = res.frame_ident;
  assign sequence_count    = res.sequence_count;
  assign received_sum      = res.received_sum;
  assign sum_ok            = res.sum_ok;
  assign payload_length    = res.payload_length;
  assign payload_head      = res.payload_head;
  assign good_frames_total = res.good_frames_total;
  assign bad_frames_total  = res.bad_frames_total;

endmodule
